// ===== rtl/siit_pkg.sv =====
package siit_pkg;

    // Fixed field widths of the request and response items.
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned IO_BOUND_W = 32;
    localparam int unsigned REGION_W = 2;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned STATUS_W = 2;

    // Request action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // One request item.
    typedef struct packed {
        logic [ACTION_W-1:0]          action;
        logic signed [IO_BOUND_W-1:0] band_low;
        logic signed [IO_BOUND_W-1:0] band_high;
        logic [REGION_W-1:0]          band_region;
        logic [INDEX_W-1:0]           read_index;
    } req_t;

    // One response item.
    typedef struct packed {
        logic signed [IO_BOUND_W-1:0] entry_low;
        logic signed [IO_BOUND_W-1:0] entry_high;
        logic [REGION_W-1:0]          entry_region;
        logic [COUNT_W-1:0]           entry_count;
        logic [STATUS_W-1:0]          status;
    } rsp_t;

    // Per-cell control from the table controller.
    typedef struct packed {
        logic ins_en;   // an insert is applied this cycle
        logic in_use;   // this cell holds a band
        logic at_end;   // this cell is the first free slot
        logic left_gt;  // left neighbor holds a band greater than the new one
    } cell_ctl_t;

endpackage

// ===== rtl/siit_cell.sv =====
module siit_cell
    import siit_pkg::*;
#(
    parameter int unsigned BOUND_BITS = 32
) (
    input  logic                         clk,
    input  cell_ctl_t                    ctl,
    input  logic signed [BOUND_BITS-1:0] new_low,
    input  logic signed [BOUND_BITS-1:0] new_high,
    input  logic [REGION_W-1:0]          new_region,
    input  logic signed [BOUND_BITS-1:0] left_low,
    input  logic signed [BOUND_BITS-1:0] left_high,
    input  logic [REGION_W-1:0]          left_region,
    output logic                         gt,
    output logic signed [BOUND_BITS-1:0] low,
    output logic signed [BOUND_BITS-1:0] high,
    output logic [REGION_W-1:0]          region
);

    logic signed [BOUND_BITS-1:0] low_reg;
    logic signed [BOUND_BITS-1:0] high_reg;
    logic [REGION_W-1:0]          region_reg;
    logic                         place;

    // The held band is greater than the new one: lower bound first, then upper.
    assign gt = ctl.in_use &&
                ((new_low < low_reg) || ((new_low == low_reg) && (new_high < high_reg)));

    // The new band lands in the first greater cell, or in the first free cell.
    assign place = (gt || ctl.at_end) && !ctl.left_gt;

    // Shift from the left neighbor or take the new band on an insert.
    always_ff @(posedge clk)
    begin
        if (ctl.ins_en)
        begin
            if (ctl.left_gt)
            begin
                low_reg    <= left_low;
                high_reg   <= left_high;
                region_reg <= left_region;
            end
            else if (place)
            begin
                low_reg    <= new_low;
                high_reg   <= new_high;
                region_reg <= new_region;
            end
        end
    end

    assign low    = low_reg;
    assign high   = high_reg;
    assign region = region_reg;

endmodule

// ===== rtl/sorted_interval_insert_table_core.sv =====
// Sorted band table.
// Requests arrive on req with req_valid and req_stall; each request yields
// exactly one response on rsp with rsp_valid and rsp_stall. A transfer takes
// place at a rising edge where valid is high and stall is low.
// A request clears the table, inserts a band in sorted position (after all
// equal bands), or reads the entry at a sorted position.
// The response is registered, appearing in the cycle after the request transfer;
// the block takes one request per cycle while req_stall is low, and the row of
// compare-and-shift cells settles an insert, all cells comparing against the new band at once.
// Results sit in one output register; while the receiver stalls and that
// register is full, req_stall is raised and the held response stays unchanged.
// An insert into a full table is dropped with status full; a read at a
// position not below the count returns zero fields and status out of range.
// Reset empties the table and the output register; band contents are not
// cleared, as only held positions are ever read.
module sorted_interval_insert_table_core
    import siit_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned BOUND_BITS  = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0]  held_count_reg;
    logic [CNT_W-1:0]  held_count_next;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              req_xfer;
    logic              full;
    logic              ins_en;
    logic              read_ok;

    logic signed [63:0]           low_ext;
    logic signed [63:0]           high_ext;
    logic signed [BOUND_BITS-1:0] new_low;
    logic signed [BOUND_BITS-1:0] new_high;

    logic signed [BOUND_BITS-1:0] cell_low    [MAX_ENTRIES];
    logic signed [BOUND_BITS-1:0] cell_high   [MAX_ENTRIES];
    logic [REGION_W-1:0]          cell_region [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]       cell_gt;

    logic signed [BOUND_BITS-1:0] sel_low;
    logic signed [BOUND_BITS-1:0] sel_high;
    logic [REGION_W-1:0]          sel_region;
    logic signed [63:0]           sel_low_ext;
    logic signed [63:0]           sel_high_ext;

    // Handshake: accept while the output register is free or being emptied.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full    = (held_count_reg == CNT_W'(MAX_ENTRIES));
    assign ins_en  = req_xfer && (req.action == ACT_INSERT) && !full;
    assign read_ok = (32'(req.read_index) < 32'(held_count_reg));

    // Input bounds are sign-extended, then kept at the table width.
    assign low_ext  = 64'(req.band_low);
    assign high_ext = 64'(req.band_high);
    assign new_low  = low_ext[BOUND_BITS-1:0];
    assign new_high = high_ext[BOUND_BITS-1:0];

    // Row of compare-and-shift cells.
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        cell_ctl_t                    ctl;
        logic signed [BOUND_BITS-1:0] left_low;
        logic signed [BOUND_BITS-1:0] left_high;
        logic [REGION_W-1:0]          left_region;

        if (k == 0)
        begin : g_first
            assign ctl.left_gt  = 1'b0;
            assign left_low     = '0;
            assign left_high    = '0;
            assign left_region  = '0;
        end
        else
        begin : g_rest
            assign ctl.left_gt  = cell_gt[k-1];
            assign left_low     = cell_low[k-1];
            assign left_high    = cell_high[k-1];
            assign left_region  = cell_region[k-1];
        end

        assign ctl.ins_en = ins_en;
        assign ctl.in_use = (CNT_W'(k) < held_count_reg);
        assign ctl.at_end = (CNT_W'(k) == held_count_reg);

        siit_cell #(
            .BOUND_BITS (BOUND_BITS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .new_low     (new_low),
            .new_high    (new_high),
            .new_region  (req.band_region),
            .left_low    (left_low),
            .left_high   (left_high),
            .left_region (left_region),
            .gt          (cell_gt[k]),
            .low         (cell_low[k]),
            .high        (cell_high[k]),
            .region      (cell_region[k])
        );
    end

    // Read-out select across the row.
    always_comb
    begin
        sel_low    = '0;
        sel_high   = '0;
        sel_region = '0;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            if (32'(k) == 32'(req.read_index))
            begin
                sel_low    = cell_low[k];
                sel_high   = cell_high[k];
                sel_region = cell_region[k];
            end
        end
    end

    assign sel_low_ext  = 64'(sel_low);
    assign sel_high_ext = 64'(sel_high);

    // Next count and response for the current request.
    always_comb
    begin
        held_count_next      = held_count_reg;
        rsp_next.entry_low    = '0;
        rsp_next.entry_high   = '0;
        rsp_next.entry_region = '0;
        rsp_next.status       = STAT_OK;
        case (req.action)
            ACT_CLEAR:
            begin
                held_count_next = '0;
            end
            ACT_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    held_count_next = held_count_reg + CNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (read_ok)
                begin
                    rsp_next.entry_low    = sel_low_ext[IO_BOUND_W-1:0];
                    rsp_next.entry_high   = sel_high_ext[IO_BOUND_W-1:0];
                    rsp_next.entry_region = sel_region;
                end
                else
                begin
                    rsp_next.status = STAT_RANGE;
                end
            end
            default:
            begin
                held_count_next = held_count_reg;
            end
        endcase
        rsp_next.entry_count = COUNT_W'(held_count_next);
    end

    // Count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_xfer)
            begin
                held_count_reg <= held_count_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
